// ===== design/rlcseg_pkg.sv =====
// Shared types and codes for the RLC UM transmit segmenter.
// Item structs, result codes, SI codes and controller command struct.
// No dependencies.
`default_nettype none

package rlcseg_pkg;

   typedef struct packed {
      logic        opcode;
      logic [15:0] sdu_length;
      logic [15:0] grant_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  segment_info;
      logic [11:0] sequence_number;
      logic [15:0] segment_offset;
      logic [2:0]  header_length;
      logic [31:0] header_word;
      logic [15:0] data_length;
      logic [15:0] pdu_length;
      logic [6:0]  queued_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_GRANT   = 1'b1;

   localparam logic CSR_SN_MODE     = 1'b0;
   localparam logic CSR_QUEUE_LIMIT = 1'b1;

   localparam logic [2:0] ST_ACCEPTED  = 3'd0;
   localparam logic [2:0] ST_DROPPED   = 3'd1;
   localparam logic [2:0] ST_PDU       = 3'd2;
   localparam logic [2:0] ST_NO_DATA   = 3'd3;
   localparam logic [2:0] ST_TOO_SMALL = 3'd4;

   localparam logic [1:0] SI_FULL   = 2'd0;
   localparam logic [1:0] SI_FIRST  = 2'd1;
   localparam logic [1:0] SI_LAST   = 2'd2;
   localparam logic [1:0] SI_MIDDLE = 2'd3;

   localparam logic [6:0] QUEUE_LIMIT_RESET = 7'd64;

endpackage

`default_nettype wire

// ===== design/rlcseg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rlcseg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/rlcseg_ctrl.sv =====
// Controller of the segmenter: two-state sequencer that loads and executes one beat.
// Depends on rlcseg_pkg.
`default_nettype none

module rlcseg_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   output logic                           csr_ready,
   output logic                           rsp_valid,
   output rlcseg_pkg::ctrl_cmd_type       cmd
);
   import rlcseg_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   assign cmd.load  = start && (state_ff == S_IDLE);
   assign cmd.exec  = (state_ff == S_EXEC);
   assign busy      = (state_ff == S_EXEC);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/rlcseg_datapath.sv =====
// Datapath of the segmenter: queue pointers, SDU segmentation state, header build,
// configuration registers and result register. Depends on rlcseg_pkg and rlcseg_ram.
`default_nettype none

module rlcseg_datapath #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int PDU_CAPACITY = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rlcseg_pkg::ctrl_cmd_type cmd,
   input  wire rlcseg_pkg::req_type      req_item,
   input  wire logic                     csr_write,
   input  wire logic                     csr_index,
   input  wire logic [6:0]               csr_data,
   output rlcseg_pkg::rsp_type           rsp_item
);
   import rlcseg_pkg::*;

   localparam int AW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int CXW = (CW > 7) ? CW : 7;

   logic [AW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           holding_ff, holding_in;
   logic [15:0]    remaining_ff, remaining_in;
   logic [15:0]    offset_ff, offset_in;
   logic [11:0]    seq_ff, seq_in;
   logic           sn12_ff;
   logic [6:0]     limit_ff;
   req_type        req_ff;
   logic [15:0]    space_ff, space_in;
   rsp_type        rsp_ff, rsp_in;

   logic [15:0]    ram_rd_data;
   logic           ram_wr_en;

   logic           enq_ok;
   logic           fresh;
   logic [15:0]    len;
   logic [15:0]    offset;
   logic [2:0]     seg_hdr;
   logic [1:0]     si;
   logic [2:0]     hlen;
   logic           too_small;
   logic [15:0]    room;
   logic [15:0]    move;
   logic [15:0]    len_left;
   logic [11:0]    sn;
   logic [7:0]     b0, b1, b2, b3;
   logic [11:0]    sn_out;
   logic [15:0]    so_out;
   logic           with_so;
   logic [CXW-1:0] count_ext;

   rlcseg_ram #(
      .WIDTH (16),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_ff.sdu_length),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign space_in = (req_item.grant_bytes > 16'(PDU_CAPACITY)) ?
                     16'(PDU_CAPACITY) : req_item.grant_bytes;

   assign enq_ok = (req_ff.sdu_length != 16'd0) &&
                   (CXW'(count_ff) < CXW'(QUEUE_DEPTH)) &&
                   (CXW'(count_ff) < CXW'(limit_ff));

   assign ram_wr_en = cmd.exec && (req_ff.opcode == OP_ENQUEUE) && enq_ok;

   always_comb begin
      fresh   = !holding_ff;
      len     = fresh ? ram_rd_data : remaining_ff;
      offset  = fresh ? 16'd0 : offset_ff;
      seg_hdr = sn12_ff ? 3'd4 : 3'd3;
      if (fresh) begin
         si   = (len <= space_ff - 16'd1) ? SI_FULL : SI_FIRST;
         hlen = ((si == SI_FULL) || !sn12_ff) ? 3'd1 : 3'd2;
      end else begin
         si   = ((space_ff >= 16'(seg_hdr)) && (len <= space_ff - 16'(seg_hdr))) ?
                SI_LAST : SI_MIDDLE;
         hlen = seg_hdr;
      end
      too_small = (space_ff <= 16'(hlen) + 16'd1);
      room      = space_ff - 16'(hlen);
      move      = (room >= len) ? len : room;
      len_left  = len - move;
      sn        = sn12_ff ? seq_ff : {6'd0, seq_ff[5:0]};
      with_so   = (si == SI_MIDDLE) || (si == SI_LAST);

      b0     = {si, 6'd0};
      b1     = 8'd0;
      b2     = 8'd0;
      b3     = 8'd0;
      sn_out = 12'd0;
      so_out = 16'd0;
      if (si != SI_FULL) begin
         sn_out = sn;
         if (with_so) begin
            so_out = offset;
         end
         if (sn12_ff) begin
            b0[3:0] = sn[11:8];
            b1      = sn[7:0];
            if (with_so) begin
               b2 = offset[15:8];
               b3 = offset[7:0];
            end
         end else begin
            b0[5:0] = sn[5:0];
            if (with_so) begin
               b1 = offset[15:8];
               b2 = offset[7:0];
            end
         end
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      holding_in   = holding_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      seq_in       = seq_ff;
      rsp_in       = '0;

      if (req_ff.opcode == OP_ENQUEUE) begin
         if (enq_ok) begin
            tail_in       = (tail_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            count_in      = count_ff + 1'b1;
            rsp_in.status = ST_ACCEPTED;
         end else begin
            rsp_in.status = ST_DROPPED;
         end
      end else if (!holding_ff && (count_ff == '0)) begin
         rsp_in.status = ST_NO_DATA;
      end else if ((req_ff.grant_bytes < 16'd2) || too_small) begin
         rsp_in.status = ST_TOO_SMALL;
      end else begin
         if (fresh) begin
            head_in  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
         holding_in   = (len_left != 16'd0);
         remaining_in = len_left;
         offset_in    = ((si == SI_LAST) || (len_left == 16'd0)) ? 16'd0 : offset + move;
         if (si == SI_LAST) begin
            seq_in = sn12_ff ? seq_ff + 12'd1 : {6'd0, seq_ff[5:0] + 6'd1};
         end
         rsp_in.status          = ST_PDU;
         rsp_in.segment_info    = si;
         rsp_in.sequence_number = sn_out;
         rsp_in.segment_offset  = so_out;
         rsp_in.header_length   = hlen;
         rsp_in.header_word     = {b0, b1, b2, b3};
         rsp_in.data_length     = move;
         rsp_in.pdu_length      = 16'(hlen) + move;
      end
      count_ext           = CXW'(count_in);
      rsp_in.queued_count = count_ext[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         holding_ff   <= 1'b0;
         remaining_ff <= 16'd0;
         offset_ff    <= 16'd0;
         seq_ff       <= 12'd0;
         sn12_ff      <= 1'b0;
         limit_ff     <= QUEUE_LIMIT_RESET;
      end else begin
         if (cmd.exec) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            count_ff     <= count_in;
            holding_ff   <= holding_in;
            remaining_ff <= remaining_in;
            offset_ff    <= offset_in;
            seq_ff       <= seq_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_SN_MODE:     sn12_ff  <= csr_data[0];
               CSR_QUEUE_LIMIT: limit_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_item;
         space_ff <= space_in;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

// ===== design/rlc_um_tx_segmenter_unit.sv =====
// Top level of the RLC UM transmit segmenter: controller, datapath and queue RAM.
// Depends on rlcseg_pkg, rlcseg_ctrl, rlcseg_datapath and rlcseg_ram.
//
// Usage:
// A request beat is taken at a rising edge with start high and busy low. An
// enqueue beat stores an SDU length in the queue; a grant beat builds one PDU
// descriptor from the held SDU or the next queued one.
// Each request produces exactly one result beat, shown on rsp_item for one
// cycle with rsp_valid high. The accepting edge loads the request and enters
// the execute state, whose closing edge registers the result. The receiver
// cannot stall; the result register holds only until the next result.
// No new request is taken while busy. The accepting edge does the registered
// read of the queue RAM at the head pointer; the execute state makes the
// segmentation decision and state update. busy is high only in that state;
// a new request can be taken in the same cycle its predecessor's result shows.
// Configuration writes use csr_valid/csr_ready, index 0 selects the SN size
// and index 1 the queue limit; csr_ready is low while busy.
// Reset is synchronous: it empties the queue, drops any held SDU, clears SN
// and offset, selects 6-bit SN and a queue limit of 64. Queue RAM contents
// are not cleared, and no clearing pass is needed.
`default_nettype none

module rlc_um_tx_segmenter_unit #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int PDU_CAPACITY = 8192
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire rlcseg_pkg::req_type req_item,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_index,
   input  wire logic [6:0]          csr_data,
   output logic                     rsp_valid,
   output rlcseg_pkg::rsp_type      rsp_item
);
   import rlcseg_pkg::*;

   ctrl_cmd_type cmd;

   rlcseg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   rlcseg_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PDU_CAPACITY (PDU_CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_item  (rsp_item)
   );

   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat shown while busy");

   a_accept_to_exec : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted beat did not enter execution");

   a_exec_to_rsp : assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("execution did not produce exactly one result beat");

   a_pdu_lengths : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == ST_PDU)) |->
      ((rsp_item.header_length != 3'd0) &&
       (rsp_item.pdu_length == 16'(rsp_item.header_length) + rsp_item.data_length)))
      else $error("PDU length does not match header plus data");

endmodule

`default_nettype wire

// ===== test/rlcseg_checker.sv =====
// Checker for the RLC UM transmit segmenter: watches the request, result and register channels.
// It predicts each result descriptor from its own copy of queue, SN and offset state.
// Depends on rlcseg_pkg.
`default_nettype none

module rlcseg_checker #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int PDU_CAPACITY = 8192
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire rlcseg_pkg::req_type req_item,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic                csr_index,
   input  wire logic [6:0]          csr_data,
   input  wire logic                rsp_valid,
   input  wire rlcseg_pkg::rsp_type rsp_item,
   output int                       fail_count,
   output int                       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rlcseg_pkg::*;

   logic        long_sn;
   logic [6:0]  sdu_limit;
   logic [15:0] sdu_fifo[$];
   logic        sdu_held;
   logic [15:0] held_bytes;
   logic [15:0] held_offset;
   logic [11:0] tx_sn;
   rsp_type     descriptor_q[$];
   rsp_type     want;
   int          errors = 0;

   function automatic rsp_type segment_step(req_type r);
      rsp_type     o;
      int unsigned limit, space, seg_hdr, len, offset, room, move;
      logic [11:0] sn;
      logic [7:0]  hb[4];
      int          k;
      bit          fresh;
      o = '0;
      if (r.opcode == OP_ENQUEUE) begin
         limit = (sdu_limit < QUEUE_DEPTH) ? sdu_limit : QUEUE_DEPTH;
         if (r.sdu_length != 0 && sdu_fifo.size() < limit) begin
            sdu_fifo.push_back(r.sdu_length);
            o.status = ST_ACCEPTED;
         end else begin
            o.status = ST_DROPPED;
         end
      end else if (!sdu_held && sdu_fifo.size() == 0) begin
         o.status = ST_NO_DATA;
      end else if (r.grant_bytes < 2) begin
         o.status = ST_TOO_SMALL;
      end else begin
         space   = (r.grant_bytes < PDU_CAPACITY) ? r.grant_bytes : PDU_CAPACITY;
         seg_hdr = long_sn ? 4 : 3;
         fresh   = !sdu_held;
         if (fresh) begin
            len    = sdu_fifo[0];
            offset = 0;
            o.segment_info  = (len <= space - 1) ? SI_FULL : SI_FIRST;
            o.header_length = (o.segment_info == SI_FULL) ? 3'd1 : (long_sn ? 3'd2 : 3'd1);
         end else begin
            len    = held_bytes;
            offset = held_offset;
            o.segment_info  = (space >= seg_hdr && len <= space - seg_hdr) ? SI_LAST : SI_MIDDLE;
            o.header_length = 3'(seg_hdr);
         end
         if (space <= o.header_length + 1) begin
            o = '0;
            o.status = ST_TOO_SMALL;
         end else begin
            room = space - o.header_length;
            move = (room >= len) ? len : room;
            sn   = long_sn ? tx_sn : {6'd0, tx_sn[5:0]};
            hb   = '{default: 8'd0};
            if (fresh) begin
               void'(sdu_fifo.pop_front());
            end
            hb[0] = {o.segment_info, 6'd0};
            if (o.segment_info != SI_FULL) begin
               o.sequence_number = sn;
               if (long_sn) begin
                  hb[0][3:0] = sn[11:8];
                  hb[1]      = sn[7:0];
                  k = 2;
               end else begin
                  hb[0][5:0] = sn[5:0];
                  k = 1;
               end
               if (o.segment_info == SI_MIDDLE || o.segment_info == SI_LAST) begin
                  o.segment_offset = 16'(offset);
                  hb[k]     = o.segment_offset[15:8];
                  hb[k + 1] = o.segment_offset[7:0];
               end
            end
            o.header_word = {hb[0], hb[1], hb[2], hb[3]};
            len         = len - move;
            sdu_held    = (len != 0);
            held_bytes  = 16'(len);
            held_offset = 16'(offset + move);
            if (o.segment_info == SI_LAST) begin
               tx_sn       = long_sn ? 12'(tx_sn + 1) : {6'd0, 6'(tx_sn + 1)};
               held_offset = '0;
            end
            if (!sdu_held) begin
               held_offset = '0;
            end
            o.data_length = 16'(move);
            o.pdu_length  = 16'(o.header_length + move);
            o.status      = ST_PDU;
         end
      end
      o.queued_count = 7'(sdu_fifo.size());
      return o;
   endfunction

   task automatic compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         long_sn     = 1'b0;
         sdu_limit   = QUEUE_LIMIT_RESET;
         sdu_held    = 1'b0;
         held_bytes  = '0;
         held_offset = '0;
         tx_sn       = '0;
         sdu_fifo.delete();
         descriptor_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (descriptor_q.size() == 0) begin
               $error("result beat with no request outstanding");
               errors++;
            end else begin
               want = descriptor_q.pop_front();
               compare_field("status", want.status, rsp_item.status);
               compare_field("segment_info", want.segment_info, rsp_item.segment_info);
               compare_field("sequence_number", want.sequence_number, rsp_item.sequence_number);
               compare_field("segment_offset", want.segment_offset, rsp_item.segment_offset);
               compare_field("header_length", want.header_length, rsp_item.header_length);
               compare_field("header_word", want.header_word, rsp_item.header_word);
               compare_field("data_length", want.data_length, rsp_item.data_length);
               compare_field("pdu_length", want.pdu_length, rsp_item.pdu_length);
               compare_field("queued_count", want.queued_count, rsp_item.queued_count);
            end
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            if (csr_index == CSR_SN_MODE) begin
               long_sn = csr_data[0];
            end else begin
               sdu_limit = csr_data;
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            descriptor_q.push_back(segment_step(req_item));
         end
      end
      pending_count <= descriptor_q.size();
      fail_count    <= errors;
   end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Top of the segmenter testbench: clock, reset, request and register stimulus, and verdict.
// Instantiates rlc_um_tx_segmenter_unit and rlcseg_checker; depends on rlcseg_pkg.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rlcseg_pkg::*;

   localparam int QUEUE_DEPTH  = 64;
   localparam int PDU_CAPACITY = 8192;
   localparam int PHASE_ITEMS  = 200;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   logic       busy;
   req_type    req_item  = '0;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_SN_MODE;
   logic [6:0] csr_data  = '0;
   logic       rsp_valid;
   rsp_type    rsp_item;
   int         fail_count;
   int         pending_count;

   rlc_um_tx_segmenter_unit #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PDU_CAPACITY(PDU_CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   rlcseg_checker #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PDU_CAPACITY(PDU_CAPACITY)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int random_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic req_type random_req(int enq_pct);
      req_type r;
      int      p;
      r.opcode = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_GRANT;
      p = $urandom_range(0, 99);
      if (p < 2) r.sdu_length = '0;
      else if (p < 5) r.sdu_length = 16'($urandom);
      else r.sdu_length = 16'($urandom_range(1, 400));
      p = $urandom_range(0, 99);
      if (p < 6) r.grant_bytes = 16'($urandom_range(0, 6));
      else if (p < 16) r.grant_bytes = 16'($urandom);
      else r.grant_bytes = 16'($urandom_range(2, 600));
      return r;
   endfunction

   task automatic send_beat(req_type r, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic directed(logic op, int unsigned value);
      req_type r;
      r.opcode      = op;
      r.sdu_length  = (op == OP_ENQUEUE) ? 16'(value) : 16'($urandom);
      r.grant_bytes = (op == OP_GRANT) ? 16'(value) : 16'($urandom);
      send_beat(r, random_gap());
   endtask

   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(logic sn_mode, logic [6:0] limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_SN_MODE;
      csr_data  <= {6'd0, sn_mode};
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_index <= CSR_QUEUE_LIMIT;
      csr_data  <= limit;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic       sn_mode;
      logic [6:0] limit;
      int         enq_pct;
      bit         steady;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed(OP_GRANT, 100);
      directed(OP_ENQUEUE, 0);
      directed(OP_ENQUEUE, 1);
      directed(OP_GRANT, 0);
      directed(OP_GRANT, 1);
      directed(OP_GRANT, 2);
      directed(OP_GRANT, 3);
      directed(OP_ENQUEUE, 65535);
      directed(OP_ENQUEUE, 20);
      directed(OP_GRANT, 65535);
      directed(OP_GRANT, 4);
      directed(OP_GRANT, 5);
      repeat (8) directed(OP_GRANT, 65535);
      directed(OP_GRANT, 12);
      directed(OP_GRANT, 100);
      directed(OP_ENQUEUE, 300);
      directed(OP_GRANT, 50);

      for (int ph = 0; ph < 8; ph++) begin
         steady = 1'b0;
         case (ph)
            0: begin sn_mode = 1'b1; limit = 7'd1;   enq_pct = 50; end
            1: begin sn_mode = 1'b0; limit = 7'd64;  enq_pct = 75; end
            2: begin sn_mode = 1'b1; limit = 7'd0;   enq_pct = 30; steady = 1'b1; end
            3: begin sn_mode = 1'b1; limit = 7'd127; enq_pct = 75; end
            4: begin sn_mode = 1'b0; limit = 7'($urandom_range(2, 63)); enq_pct = 45; end
            5: begin sn_mode = 1'b1; limit = 7'd64;  enq_pct = 40; steady = 1'b1; end
            6: begin sn_mode = 1'b0; limit = 7'($urandom_range(1, 64)); enq_pct = 50; end
            default: begin sn_mode = 1'($urandom); limit = 7'd64; enq_pct = 40; end
         endcase
         quiesce();
         write_regs(sn_mode, limit);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_beat(random_req(enq_pct), steady ? 0 : random_gap());
         end
      end

      start <= 1'b0;
      @(posedge clock);
      for (int w = 0; w < 1000 && pending_count != 0; w++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** rlc_um_tx_segmenter_unit: PASSED **");
      end else begin
         $display("** rlc_um_tx_segmenter_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #(20ms);
      $display("** rlc_um_tx_segmenter_unit: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
